@@ src/srt_pkg.sv @@
// ---------------------------------------------------------------------------
// srt_pkg: shared types and constants for the sorted record table
// Record layout, command and status codes, controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int KEY_W  = 64;
  localparam int NAME_W = 64;
  localparam int WGT_W  = 13;
  localparam int HGT_W  = 9;
  localparam int BMI_W  = 16;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 3;
  localparam int POS_W  = 4;
  localparam int ENT_W  = 5;
  localparam int SLOT_W = 4;
  localparam int IN_W   = 224;
  localparam int OUT_W  = 184;

  // BMI divider: weight * 10000 fits 27 bits, height squared fits 18 bits
  localparam int NUM_W  = 27;
  localparam int DEN_W  = 18;
  localparam int STEP_W = 5;
  localparam logic [NUM_W-1:0] BMI_SCALE = 27'd10000;
  localparam logic [BMI_W-1:0] BMI_MAX   = 16'hFFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_DELETE     = 3'd1,
    CMD_READ       = 3'd2,
    CMD_REKEY      = 3'd3,
    CMD_SET_NAME   = 3'd4,
    CMD_SET_WEIGHT = 3'd5,
    CMD_SET_HEIGHT = 3'd6,
    CMD_INVALID    = 3'd7
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_BADIDX   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    RA_IDX    = 2'd0,
    RA_IDX_M1 = 2'd1,
    RA_IDX_P1 = 2'd2,
    RA_SLOT   = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [NAME_W-1:0] name;
    logic [WGT_W-1:0]  weight;
    logic [HGT_W-1:0]  height;
    logic [BMI_W-1:0]  bmi;
  } record_t;

  typedef struct packed {
    logic    ld_in;
    logic    idx_clr;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_cnt;
    logic    idx_pos;
    logic    pos_idx;
    logic    pos_slot;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_shift;
    logic    hit_ld;
    logic    hit_clr;
    logic    cap_hold;
    logic    hold_new;
    logic    set_name;
    logic    set_w;
    logic    set_h;
    logic    set_nkey;
    logic    bmi_start;
    logic    bmi_cap;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    tgt_new;
    logic    res_ld;
    logic    res_rec;
    status_t res_st;
  } ctrl_t;

  typedef struct packed {
    cmd_t cmd;
    logic idx_lt_cnt;
    logic key_lt;
    logic hit;
    logic cnt_full;
    logic cnt_zero;
    logic slot_ok;
    logic up_more;
    logic dn_more;
    logic bmi_busy;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

@@ src/srt_bmi.sv @@
// ---------------------------------------------------------------------------
// srt_bmi: body-mass index unit
// Computes floor(weight * 10000 / height^2) one quotient bit per cycle,
// saturating to all ones on zero height or overflow.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_bmi (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [srt_pkg::WGT_W-1:0] weight,
  input  wire logic [srt_pkg::HGT_W-1:0] height,
  output logic                           busy,
  output logic [srt_pkg::BMI_W-1:0]      bmi
);

  logic                           busy_r;
  logic [srt_pkg::STEP_W-1:0]     step_r;
  logic [srt_pkg::NUM_W-1:0]      num_r;
  logic [srt_pkg::DEN_W-1:0]      den_r;
  logic [srt_pkg::DEN_W-1:0]      rem_r;
  logic [srt_pkg::DEN_W-1:0]      rem_nxt;
  logic [srt_pkg::DEN_W:0]        trial;
  logic                           ge;

  // one restoring step: shift in next numerator bit, try subtract
  always_comb begin
    trial   = {rem_r, num_r[srt_pkg::NUM_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? srt_pkg::DEN_W'(trial - {1'b0, den_r}) : srt_pkg::DEN_W'(trial);
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= srt_pkg::STEP_W'(srt_pkg::NUM_W);
    end else if (busy_r) begin
      step_r <= step_r - 1'b1;
      if (step_r == srt_pkg::STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // operands and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= srt_pkg::NUM_W'(weight) * srt_pkg::BMI_SCALE;
      den_r <= srt_pkg::DEN_W'(height) * srt_pkg::DEN_W'(height);
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[srt_pkg::NUM_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign bmi  = (den_r == '0 || num_r[srt_pkg::NUM_W-1:srt_pkg::BMI_W] != '0) ?
                srt_pkg::BMI_MAX : num_r[srt_pkg::BMI_W-1:0];

endmodule

`default_nettype wire

@@ src/srt_dpath.sv @@
// ---------------------------------------------------------------------------
// srt_dpath: record table datapath
// Record memory, walk index, held record, BMI unit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_dpath #(
  parameter int CAPACITY = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [srt_pkg::IN_W-1:0]  in_tdata,
  input  wire srt_pkg::ctrl_t            ctrl,
  output srt_pkg::stat_t                 stat,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [srt_pkg::OUT_W-1:0]      out_tdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + srt_pkg::SLOT_W;

  // latched command word
  srt_pkg::cmd_t                cmd_r;
  logic [srt_pkg::KEY_W-1:0]    key_r;
  logic [srt_pkg::KEY_W-1:0]    nkey_r;
  logic [srt_pkg::NAME_W-1:0]   name_r;
  logic [srt_pkg::WGT_W-1:0]    wgt_r;
  logic [srt_pkg::HGT_W-1:0]    hgt_r;
  logic [srt_pkg::SLOT_W-1:0]   slot_r;

  srt_pkg::record_t             mem [CAPACITY];
  srt_pkg::record_t             rd_r;
  srt_pkg::record_t             hold_r;
  logic [AW-1:0]                ra;
  logic [AW-1:0]                wa;
  srt_pkg::record_t             wd;

  logic [CW-1:0]                cnt_r;
  logic [CW-1:0]                idx_r;
  logic [AW-1:0]                pos_r;
  logic                         hit_r;
  logic [srt_pkg::KEY_W-1:0]    tgt;

  logic                         bmi_busy;
  logic [srt_pkg::BMI_W-1:0]    bmi_val;

  logic                         ov_r;
  srt_pkg::status_t             o_st_r;
  logic [srt_pkg::POS_W-1:0]    o_pos_r;
  logic [srt_pkg::ENT_W-1:0]    o_ent_r;
  srt_pkg::record_t             o_rec_r;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      cmd_r  <= srt_pkg::cmd_t'(in_tdata[2:0]);
      key_r  <= in_tdata[66:3];
      nkey_r <= in_tdata[130:67];
      name_r <= in_tdata[194:131];
      wgt_r  <= in_tdata[207:195];
      hgt_r  <= in_tdata[216:208];
      slot_r <= in_tdata[220:217];
    end
  end

  // memory addresses
  always_comb begin
    case (ctrl.rd_sel)
      srt_pkg::RA_IDX:    ra = idx_r[AW-1:0];
      srt_pkg::RA_IDX_M1: ra = AW'(idx_r - 1'b1);
      srt_pkg::RA_IDX_P1: ra = AW'(idx_r + 1'b1);
      default:            ra = AW'(slot_r);
    endcase
    wa = ctrl.wr_shift ? idx_r[AW-1:0] : pos_r;
    wd = ctrl.wr_shift ? rd_r : hold_r;
  end

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wa] <= wd;
    end
    if (ctrl.rd_en) begin
      rd_r <= mem[ra];
    end
  end

  // count, walk index, search result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctrl.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (ctrl.cnt_dec) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.idx_clr) begin
      idx_r <= '0;
    end else if (ctrl.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end else if (ctrl.idx_dec) begin
      idx_r <= idx_r - 1'b1;
    end else if (ctrl.idx_cnt) begin
      idx_r <= cnt_r;
    end else if (ctrl.idx_pos) begin
      idx_r <= CW'(pos_r);
    end
    if (ctrl.pos_idx) begin
      pos_r <= AW'(idx_r);
    end else if (ctrl.pos_slot) begin
      pos_r <= AW'(slot_r);
    end
    if (ctrl.hit_clr) begin
      hit_r <= 1'b0;
    end else if (ctrl.hit_ld) begin
      hit_r <= (rd_r.key == tgt);
    end
  end

  // held record: found entry, then field updates
  always_ff @(posedge clk) begin
    if (ctrl.cap_hold) begin
      hold_r <= rd_r;
    end
    if (ctrl.hold_new) begin
      hold_r.key    <= key_r;
      hold_r.name   <= name_r;
      hold_r.weight <= wgt_r;
      hold_r.height <= hgt_r;
    end
    if (ctrl.set_name) begin
      hold_r.name <= name_r;
    end
    if (ctrl.set_w) begin
      hold_r.weight <= wgt_r;
    end
    if (ctrl.set_h) begin
      hold_r.height <= hgt_r;
    end
    if (ctrl.set_nkey) begin
      hold_r.key <= nkey_r;
    end
    if (ctrl.bmi_cap) begin
      hold_r.bmi <= bmi_val;
    end
  end

  srt_bmi u_bmi (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctrl.bmi_start),
    .weight (hold_r.weight),
    .height (hold_r.height),
    .busy   (bmi_busy),
    .bmi    (bmi_val)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (ctrl.res_ld) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_ld) begin
      o_st_r  <= ctrl.res_st;
      o_ent_r <= srt_pkg::ENT_W'(cnt_r);
      o_pos_r <= ctrl.res_rec ? srt_pkg::POS_W'(pos_r) : '0;
      o_rec_r <= ctrl.res_rec ? hold_r : '0;
    end
  end

  // status toward the controller
  always_comb begin
    tgt             = ctrl.tgt_new ? nkey_r : key_r;
    stat.cmd        = cmd_r;
    stat.idx_lt_cnt = idx_r < cnt_r;
    stat.key_lt     = rd_r.key < tgt;
    stat.hit        = hit_r;
    stat.cnt_full   = cnt_r == CW'(CAPACITY);
    stat.cnt_zero   = cnt_r == '0;
    stat.slot_ok    = SW'(slot_r) < SW'(cnt_r);
    stat.up_more    = idx_r > CW'(pos_r);
    stat.dn_more    = (CW+1)'(idx_r) + 1'b1 < (CW+1)'(cnt_r);
    stat.bmi_busy   = bmi_busy;
    stat.out_free   = !ov_r || out_tready;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, o_rec_r.bmi, o_rec_r.height, o_rec_r.weight,
                       o_rec_r.name, o_rec_r.key, o_ent_r, o_pos_r, o_st_r};

endmodule

`default_nettype wire

@@ src/srt_ctrl.sv @@
// ---------------------------------------------------------------------------
// srt_ctrl: record table controller
// Sequences search, shift, BMI and write steps for each command word.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire srt_pkg::stat_t  stat,
  output srt_pkg::ctrl_t       ctrl
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_DECIDE   = 14'b00000000000010,
    S_SRD      = 14'b00000000000100,
    S_SCMP     = 14'b00000000001000,
    S_RD_SLOT  = 14'b00000000010000,
    S_CAP_SLOT = 14'b00000000100000,
    S_UP_CHK   = 14'b00000001000000,
    S_UP_WR    = 14'b00000010000000,
    S_DN_CHK   = 14'b00000100000000,
    S_DN_WR    = 14'b00001000000000,
    S_BMI_GO   = 14'b00010000000000,
    S_BMI_WAIT = 14'b00100000000000,
    S_WRITE    = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_FIND  = 2'd1,
    PH_NEW   = 2'd2,
    PH_PLACE = 2'd3
  } phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  srt_pkg::status_t st_r, st_nxt;
  logic             rec_r, rec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_START;
      st_r    <= srt_pkg::ST_OK;
      rec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      st_r    <= st_nxt;
      rec_r   <= rec_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    st_nxt       = st_r;
    rec_nxt      = rec_r;
    ctrl         = '0;
    ctrl.rd_sel  = srt_pkg::RA_IDX;
    ctrl.res_st  = st_r;
    ctrl.tgt_new = (phase_r != PH_FIND);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          ctrl.ld_in = 1'b1;
          phase_nxt  = PH_START;
          state_nxt  = S_DECIDE;
        end
      end

      S_DECIDE: begin
        rec_nxt   = 1'b0;
        state_nxt = S_FIN;
        unique case (phase_r)
          PH_START: begin
            if (stat.cmd == srt_pkg::CMD_INVALID) begin
              st_nxt = srt_pkg::ST_BADIDX;
            end else if (stat.cmd == srt_pkg::CMD_INSERT && stat.cnt_full) begin
              st_nxt = srt_pkg::ST_FULL;
            end else if (stat.cmd != srt_pkg::CMD_INSERT && stat.cnt_zero) begin
              st_nxt = srt_pkg::ST_EMPTY;
            end else if (stat.cmd == srt_pkg::CMD_READ) begin
              if (stat.slot_ok) begin
                state_nxt = S_RD_SLOT;
              end else begin
                st_nxt = srt_pkg::ST_BADIDX;
              end
            end else begin
              ctrl.idx_clr = 1'b1;
              phase_nxt    = PH_FIND;
              state_nxt    = S_SRD;
            end
          end
          PH_FIND: begin
            if (stat.cmd == srt_pkg::CMD_INSERT) begin
              if (stat.hit) begin
                st_nxt = srt_pkg::ST_DUP;
              end else begin
                ctrl.pos_idx  = 1'b1;
                ctrl.hold_new = 1'b1;
                ctrl.idx_cnt  = 1'b1;
                state_nxt     = S_UP_CHK;
              end
            end else if (!stat.hit) begin
              st_nxt = srt_pkg::ST_NOTFOUND;
            end else begin
              ctrl.pos_idx = 1'b1;
              case (stat.cmd)
                srt_pkg::CMD_DELETE: state_nxt = S_DN_CHK;
                srt_pkg::CMD_REKEY: begin
                  ctrl.idx_clr = 1'b1;
                  phase_nxt    = PH_NEW;
                  state_nxt    = S_SRD;
                end
                srt_pkg::CMD_SET_NAME: begin
                  ctrl.set_name = 1'b1;
                  state_nxt     = S_WRITE;
                end
                srt_pkg::CMD_SET_WEIGHT: begin
                  ctrl.set_w = 1'b1;
                  state_nxt  = S_BMI_GO;
                end
                default: begin
                  ctrl.set_h = 1'b1;
                  state_nxt  = S_BMI_GO;
                end
              endcase
            end
          end
          PH_NEW: begin
            if (stat.hit) begin
              st_nxt = srt_pkg::ST_DUP;
            end else begin
              ctrl.idx_pos = 1'b1;
              state_nxt    = S_DN_CHK;
            end
          end
          default: begin
            ctrl.pos_idx  = 1'b1;
            ctrl.set_nkey = 1'b1;
            ctrl.idx_cnt  = 1'b1;
            state_nxt     = S_UP_CHK;
          end
        endcase
      end

      // walk up from index 0 until key >= target
      S_SRD: begin
        if (stat.idx_lt_cnt) begin
          ctrl.rd_en = 1'b1;
          state_nxt  = S_SCMP;
        end else begin
          ctrl.hit_clr = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end

      S_SCMP: begin
        if (stat.key_lt) begin
          ctrl.idx_inc = 1'b1;
          state_nxt    = S_SRD;
        end else begin
          ctrl.hit_ld   = 1'b1;
          ctrl.cap_hold = (phase_r == PH_FIND);
          state_nxt     = S_DECIDE;
        end
      end

      S_RD_SLOT: begin
        ctrl.rd_en    = 1'b1;
        ctrl.rd_sel   = srt_pkg::RA_SLOT;
        ctrl.pos_slot = 1'b1;
        state_nxt     = S_CAP_SLOT;
      end

      S_CAP_SLOT: begin
        ctrl.cap_hold = 1'b1;
        st_nxt        = srt_pkg::ST_OK;
        rec_nxt       = 1'b1;
        state_nxt     = S_FIN;
      end

      // open a gap at pos, moving entries up one
      S_UP_CHK: begin
        if (stat.up_more) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = srt_pkg::RA_IDX_M1;
          state_nxt   = S_UP_WR;
        end else if (stat.cmd == srt_pkg::CMD_INSERT) begin
          state_nxt = S_BMI_GO;
        end else begin
          state_nxt = S_WRITE;
        end
      end

      S_UP_WR: begin
        ctrl.wr_en    = 1'b1;
        ctrl.wr_shift = 1'b1;
        ctrl.idx_dec  = 1'b1;
        state_nxt     = S_UP_CHK;
      end

      // close the gap at pos, moving entries down one
      S_DN_CHK: begin
        if (stat.dn_more) begin
          ctrl.rd_en  = 1'b1;
          ctrl.rd_sel = srt_pkg::RA_IDX_P1;
          state_nxt   = S_DN_WR;
        end else begin
          ctrl.cnt_dec = 1'b1;
          if (stat.cmd == srt_pkg::CMD_DELETE) begin
            st_nxt    = srt_pkg::ST_OK;
            rec_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            ctrl.idx_clr = 1'b1;
            phase_nxt    = PH_PLACE;
            state_nxt    = S_SRD;
          end
        end
      end

      S_DN_WR: begin
        ctrl.wr_en    = 1'b1;
        ctrl.wr_shift = 1'b1;
        ctrl.idx_inc  = 1'b1;
        state_nxt     = S_DN_CHK;
      end

      S_BMI_GO: begin
        ctrl.bmi_start = 1'b1;
        state_nxt      = S_BMI_WAIT;
      end

      S_BMI_WAIT: begin
        if (!stat.bmi_busy) begin
          ctrl.bmi_cap = 1'b1;
          state_nxt    = S_WRITE;
        end
      end

      S_WRITE: begin
        ctrl.wr_en   = 1'b1;
        ctrl.cnt_inc = (stat.cmd == srt_pkg::CMD_INSERT) ||
                       (stat.cmd == srt_pkg::CMD_REKEY);
        st_nxt       = srt_pkg::ST_OK;
        rec_nxt      = 1'b1;
        state_nxt    = S_FIN;
      end

      // hold until the result register is free
      S_FIN: begin
        if (stat.out_free) begin
          ctrl.res_ld  = 1'b1;
          ctrl.res_rec = rec_r;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ src/sorted_record_table_top.sv @@
// ---------------------------------------------------------------------------
// sorted_record_table_top: sorted record table
// Holds up to CAPACITY records in ascending key order and serves commands.
// ---------------------------------------------------------------------------
// Usage: one command word in on the in_ channel, exactly one result word out
// on the out_ channel. The block works on one command at a time: in_tready is
// high only while it is idle, and it may already be high while the previous
// result still waits in the output register.
// Command timing: a key search reads one entry at a time, stepping up from
// index 0; each record moved by insert, delete or rekey is read and then
// written back, and a BMI update runs the 27-step divider. Read at index
// needs no search. The record memory's single read and write port sets
// the walk rate.
// Reset empties the table (count to zero) and drops any pending result;
// the record memory itself is not cleared. If out_tready stays low, the
// finished result holds and the block waits before loading the next one.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_record_table_top #(
  parameter int CAPACITY = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // cmd, key, new_key, name_tag, weight_dkg, height_cm, slot (from bit 0)
  input  wire logic [srt_pkg::IN_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // status, position, entries, out_key, out_name, out_weight, out_height,
  // out_bmi_x100 (from bit 0)
  output logic [srt_pkg::OUT_W-1:0]      out_tdata
);

  srt_pkg::ctrl_t ctrl;
  srt_pkg::stat_t stat;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  srt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ src/srt_chk.sv @@
// ---------------------------------------------------------------------------
// srt_chk: port checker for the sorted record table
// Watches the stream ports for result and handshake consistency.
// ---------------------------------------------------------------------------
`default_nettype none

module srt_chk (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_tvalid,
  input wire logic                     in_tready,
  input wire logic                     out_tvalid,
  input wire logic                     out_tready,
  input wire logic [srt_pkg::OUT_W-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a failed command carries no record
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != srt_pkg::ST_OK |->
      out_tdata[6:3] == '0 && out_tdata[177:12] == '0)
    else $error("failed command returned record fields");

  // one command at a time: busy right after an accepted word
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

endmodule

bind sorted_record_table_top srt_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
